// ===== rtl/core/tabular_q_learning_agent_defines.svh =====
// assertion macros for the q-learning agent checker
// no dependencies; included by files that assert
`ifndef TABULAR_Q_LEARNING_AGENT_DEFINES_SVH
`define TABULAR_Q_LEARNING_AGENT_DEFINES_SVH

// checked only while out of reset
`define TQL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tql assertion failed");

// checked at every edge, reset included
`define TQL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tql assertion failed");

`endif

// ===== rtl/core/tql_pkg.sv =====
// shared types and constants of the q-learning agent
// no dependencies; imported by tql_ram, tql_dp, tql_ctrl and the top level
package tql_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int ACT_W       = 3;
  localparam int QW          = 32;
  localparam int FW          = 16;
  localparam int GM_PW       = QW + FW + 1;
  localparam int GM_W        = GM_PW - FW;
  localparam int DW          = QW + 3;
  localparam int DP_W        = DW + FW + 1;
  localparam int DL_W        = DP_W - FW;
  localparam int SUM_W       = DL_W + 1;

  localparam logic [ACT_W:0] ACT_CAP = (ACT_W + 1)'((NUM_ACTIONS < 8) ? NUM_ACTIONS : 8);

  localparam logic [1:0] REG_LEARNING_RATE  = 2'd0;
  localparam logic [1:0] REG_DISCOUNT       = 2'd1;
  localparam logic [1:0] REG_EXPLORE_RATE   = 2'd2;
  localparam logic [1:0] REG_ACTIONS_IN_USE = 2'd3;

  typedef logic signed [QW-1:0] q_t;
  typedef q_t [NUM_ACTIONS-1:0] row_t;

  typedef struct packed {
    logic              func;
    logic [7:0]        previous_state;
    logic [2:0]        taken_action;
    logic [7:0]        current_state;
    logic signed [31:0] reward;
    logic [15:0]       explore_draw;
    logic [2:0]        random_action;
  } in_t;

  typedef struct packed {
    logic [2:0] chosen_action;
    logic       explored;
  } out_t;

  typedef struct packed {
    logic accept;
    logic rd_cur;
    logic ld_cur;
    logic scan;
    logic finish;
    logic rd_prev;
    logic ld_prev;
    logic mul1;
    logic diff;
    logic mul2;
    logic wr;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic update_pending;
  } dp_sts_t;

endpackage

// ===== rtl/core/tql_ram.sv =====
// q table: one row of all action values per state, registered read
// row valid flags stand for the all-zero reset; depends on tql_pkg
module tql_ram import tql_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [STATE_W-1:0] rd_addr_i,
  output row_t               rd_row_o,
  input  logic               wr_en_i,
  input  logic [STATE_W-1:0] wr_addr_i,
  input  row_t               wr_row_i
);

  row_t                  mem_q [NUM_STATES];
  row_t                  rd_data_q;
  logic                  rd_valid_q;
  logic [NUM_STATES-1:0] row_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/tql_dp.sv =====
// datapath: row registers, argmax scan, td update arithmetic, result register
// depends on tql_pkg; drives the q table ports
module tql_dp import tql_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  in_t                item_i,
  input  logic [15:0]        learning_rate_i,
  input  logic [15:0]        discount_i,
  input  logic [15:0]        explore_rate_i,
  input  logic [ACT_W:0]     n_act_i,
  output logic               rd_en_o,
  output logic [STATE_W-1:0] rd_addr_o,
  input  row_t               rd_row_i,
  output logic               wr_en_o,
  output logic [STATE_W-1:0] wr_addr_o,
  output row_t               wr_row_o,
  output logic               result_valid_o,
  output out_t               result_o
);

  in_t                     item_q;
  row_t                    cur_row_q;
  row_t                    prev_row_q;
  logic [ACT_W-1:0]        best_q, best_d;
  logic [ACT_W-1:0]        idx_q;
  logic signed [GM_W-1:0]  gm_q;
  logic signed [DW-1:0]    diff_q;
  logic signed [DL_W-1:0]  delta_q;
  out_t                    res_q;
  logic                    valid_q;
  logic                    done_q;

  logic signed [QW-1:0]    max_q;
  logic signed [QW-1:0]    old_q;
  logic signed [GM_PW-1:0] gm_prod;
  logic signed [DW-1:0]    diff_d;
  logic signed [DP_W-1:0]  dl_prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [QW-1:0]    new_q;
  logic                    update_en;
  logic                    explore;
  logic [ACT_W-1:0]        n_last;
  logic [ACT_W-1:0]        rnd_act;

  assign max_q = $signed(cur_row_q[best_q]);
  assign old_q = $signed(prev_row_q[item_q.taken_action]);

  assign gm_prod = max_q * $signed({1'b0, discount_i});
  assign diff_d  = $signed({{(DW-QW){item_q.reward[QW-1]}}, item_q.reward})
                 + $signed({{(DW-GM_W){gm_q[GM_W-1]}}, gm_q})
                 - $signed({{(DW-QW){old_q[QW-1]}}, old_q});
  assign dl_prod = diff_q * $signed({1'b0, learning_rate_i});
  assign sum     = $signed({{(SUM_W-QW){old_q[QW-1]}}, old_q})
                 + $signed({delta_q[DL_W-1], delta_q});

  always_comb begin
    if (sum[SUM_W-1:QW-1] == '0 || sum[SUM_W-1:QW-1] == '1) begin
      new_q = sum[QW-1:0];
    end else if (sum[SUM_W-1]) begin
      new_q = {1'b1, {(QW-1){1'b0}}};
    end else begin
      new_q = {1'b0, {(QW-1){1'b1}}};
    end
  end

  always_comb begin
    wr_row_o = prev_row_q;
    wr_row_o[item_q.taken_action] = new_q;
  end

  always_comb begin
    best_d = best_q;
    if ({1'b0, idx_q} < n_act_i &&
        $signed(cur_row_q[idx_q]) > $signed(cur_row_q[best_q])) begin
      best_d = idx_q;
    end
  end

  assign update_en = item_q.func && ({1'b0, item_q.taken_action} < n_act_i);
  assign n_last    = ACT_W'(n_act_i - 1'b1);
  assign rnd_act   = (item_q.random_action > n_last) ? n_last : item_q.random_action;
  assign explore   = item_q.explore_draw < explore_rate_i;

  assign sts_o.scan_last      = ({1'b0, idx_q} + 1'b1) >= n_act_i;
  assign sts_o.update_pending = update_en && !done_q;

  assign rd_en_o   = cmd_i.rd_cur || cmd_i.rd_prev;
  assign rd_addr_o = cmd_i.rd_prev ? item_q.previous_state[STATE_W-1:0]
                                   : item_q.current_state[STATE_W-1:0];
  assign wr_en_o   = cmd_i.wr;
  assign wr_addr_o = item_q.previous_state[STATE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
    if (cmd_i.ld_cur) begin
      cur_row_q <= rd_row_i;
      best_q    <= '0;
      idx_q     <= ACT_W'(1);
    end
    if (cmd_i.scan) begin
      best_q <= best_d;
      idx_q  <= idx_q + 1'b1;
    end
    if (cmd_i.ld_prev) begin
      prev_row_q <= rd_row_i;
    end
    if (cmd_i.mul1) begin
      gm_q <= gm_prod[GM_PW-1:FW];
    end
    if (cmd_i.diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mul2) begin
      delta_q <= dl_prod[DP_W-1:FW];
    end
    if (cmd_i.finish) begin
      res_q.chosen_action <= explore ? rnd_act : best_d;
      res_q.explored      <= explore;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cmd_i.accept) begin
        done_q <= 1'b0;
      end else if (cmd_i.wr) begin
        done_q <= 1'b1;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/core/tql_ctrl.sv =====
// controller: sequences row reads, argmax scan, update and write-back
// depends on tql_pkg; commands tql_dp
module tql_ctrl import tql_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDC  = 4'd1;
  localparam logic [3:0] S_LDC  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_RDP  = 4'd4;
  localparam logic [3:0] S_LDP  = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RDC;
        end
      end
      S_RDC: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_LDC;
      end
      S_LDC: begin
        cmd_o.ld_cur = 1'b1;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          if (sts_i.update_pending) begin
            state_d = S_RDP;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_RDP: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_LDP;
      end
      S_LDP: begin
        cmd_o.ld_prev = 1'b1;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_RDC;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// ===== rtl/core/tabular_q_learning_agent.sv =====
// top level of the tabular q-learning agent: config registers and hookup
// depends on tql_pkg, tql_ram, tql_dp, tql_ctrl
//
// An item is taken when start is high and busy is low; its result appears on
// result_o for one cycle with result_valid_o and cannot be held off. A
// select-only item (or one whose taken action is out of use) reads and scans
// the current row; an update also reads, updates and writes back the previous
// row, then reads and scans the current row again. No new item is taken until
// busy falls. Busy time is set by the argmax, which walks the current row
// through one comparator a cycle, by the row memory (one registered read per row,
// and the current row read again after write-back), and by the two multiplies
// of the update. The q table resets to zero at once through per-row valid flags.
module tabular_q_learning_agent import tql_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         cmd_i,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]    learning_rate_q;
  logic [15:0]    discount_q;
  logic [15:0]    explore_rate_q;
  logic [3:0]     actions_in_use_q;
  logic [1:0]     reg_idx;
  logic           cfg_we;
  logic [ACT_W:0] n_act;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic               rd_en;
  logic [STATE_W-1:0] rd_addr;
  row_t               rd_row;
  logic               wr_en;
  logic [STATE_W-1:0] wr_addr;
  row_t               wr_row;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q  <= 16'd6554;
      discount_q       <= 16'd58982;
      explore_rate_q   <= 16'd6554;
      actions_in_use_q <= 4'd8;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_LEARNING_RATE:  learning_rate_q  <= pwdata[15:0];
        REG_DISCOUNT:       discount_q       <= pwdata[15:0];
        REG_EXPLORE_RATE:   explore_rate_q   <= pwdata[15:0];
        REG_ACTIONS_IN_USE: actions_in_use_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEARNING_RATE:  prdata = {16'd0, learning_rate_q};
      REG_DISCOUNT:       prdata = {16'd0, discount_q};
      REG_EXPLORE_RATE:   prdata = {16'd0, explore_rate_q};
      REG_ACTIONS_IN_USE: prdata = {28'd0, actions_in_use_q};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    if (actions_in_use_q == '0) begin
      n_act = (ACT_W + 1)'(1);
    end else if ((ACT_W + 1)'(actions_in_use_q) > ACT_CAP) begin
      n_act = ACT_CAP;
    end else begin
      n_act = (ACT_W + 1)'(actions_in_use_q);
    end
  end

  tql_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  tql_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .item_i          (cmd_i),
    .learning_rate_i (learning_rate_q),
    .discount_i      (discount_q),
    .explore_rate_i  (explore_rate_q),
    .n_act_i         (n_act),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_row_i        (rd_row),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_row_o        (wr_row),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o)
  );

  tql_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row)
  );

endmodule

// ===== rtl/core/tql_checker.sv =====
// port-level checker of the q-learning agent, bound to the top level
// depends on tabular_q_learning_agent_defines.svh
`include "tabular_q_learning_agent_defines.svh"

module tql_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic pready
);

  `TQL_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy)
  `TQL_ASSERT(a_busy_from_start, clk_i, rst_ni, $rose(busy) |-> $past(start))
  `TQL_ASSERT(a_result_idle, clk_i, rst_ni, result_valid_o |-> !busy)
  `TQL_ASSERT(a_result_pulse, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  `TQL_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !busy && !result_valid_o && pready)

endmodule

bind tabular_q_learning_agent tql_checker u_tql_checker (.*);
